[hw/rtl/dtu_pkg.sv]
// ----------------------------------------------------------------------------
// dtu_pkg
// Shared types and constants for the broadcast text to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package dtu_pkg;

  localparam int OUT_LIMIT_DEF = 4096;
  localparam int Q_DEPTH       = 4;
  localparam int CNT_W         = 13;
  localparam int CP_W          = 21;

  // active table of the current string
  localparam logic [2:0] M_SEL   = 3'd0;
  localparam logic [2:0] M_PASS  = 3'd1;
  localparam logic [2:0] M_UCS   = 3'd2;
  localparam logic [2:0] M_BE    = 3'd3;
  localparam logic [2:0] M_LE    = 3'd4;
  localparam logic [2:0] M_UNSUP = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_PAIR = 2'd1;
  localparam logic [1:0] ST_UNSUP    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             out_valid;
    logic             out_last;
    logic [1:0]       status;
    logic [CNT_W-1:0] consumed_count;
  } out_item_t;

  // one classified input byte: a code point to encode plus end information
  typedef struct packed {
    logic [CP_W-1:0]  code;
    logic [2:0]       nbytes;
    logic             last;
    logic [1:0]       status;
    logic [CNT_W-1:0] consumed;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[hw/rtl/dtu_front.sv]
// ----------------------------------------------------------------------------
// dtu_front
// Accepts input bytes, tracks string state and turns bytes that give output or end a string into jobs.
// ----------------------------------------------------------------------------
module dtu_front #(
  parameter int OUT_LIMIT = dtu_pkg::OUT_LIMIT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  dtu_pkg::in_item_t in_data,
  input  dtu_pkg::q_status_t q_stat,
  output logic             q_push,
  output dtu_pkg::job_t    q_job
);
  import dtu_pkg::*;

  localparam int OCW = $clog2(OUT_LIMIT + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  logic [1:0]       fallback_r;
  logic [2:0]       active_mode_r, active_mode_nxt;
  logic [1:0]       unit_phase_r, unit_phase_nxt;
  logic [7:0]       held_byte_r, held_byte_nxt;
  logic [9:0]       held_high_r, held_high_nxt;
  logic             stopped_r, stopped_nxt;
  logic [CNT_W-1:0] in_count_r, in_count_nxt;
  logic [OCW-1:0]   out_count_r, out_count_nxt;
  logic [1:0]       error_code_r, error_code_nxt;

  logic [2:0]       mode;
  logic [1:0]       phase;
  logic [7:0]       hbyte;
  logic             stop;
  logic [CNT_W-1:0] icnt;
  logic [OCW-1:0]   ocnt;
  logic [1:0]       err;
  logic [7:0]       b;
  logic [15:0]      w;
  logic [CP_W-1:0]  cp;
  logic [2:0]       n;
  logic [2:0]       kcons;
  logic [CNT_W:0]   icnt_sum;
  logic             accept;

  function automatic logic [2:0] utf8_len(input logic [15:0] c);
    logic [2:0] r;
    if (c == 16'd0) r = 3'd0;
    else if (c < 16'h0080) r = 3'd1;
    else if (c < 16'h0800) r = 3'd2;
    else r = 3'd3;
    return r;
  endfunction

  function automatic logic [2:0] start_mode(input logic [1:0] f);
    logic [2:0] r;
    case (f)
      2'd0:    r = M_SEL;
      2'd1:    r = M_UCS;
      2'd2:    r = M_BE;
      default: r = M_LE;
    endcase
    return r;
  endfunction

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign b        = in_data.in_byte;

  always_comb begin
    // a first byte restarts the string before it is looked at
    if (in_data.first_byte) begin
      mode  = start_mode(fallback_r);
      phase = 2'd0;
      hbyte = 8'd0;
      stop  = 1'b0;
      icnt  = '0;
      ocnt  = '0;
      err   = ST_OK;
    end else begin
      mode  = active_mode_r;
      phase = unit_phase_r;
      hbyte = held_byte_r;
      stop  = stopped_r;
      icnt  = in_count_r;
      ocnt  = out_count_r;
      err   = error_code_r;
    end

    w = (mode == M_BE) ? {hbyte, b} : {b, hbyte};

    active_mode_nxt = mode;
    unit_phase_nxt  = phase;
    held_byte_nxt   = hbyte;
    held_high_nxt   = in_data.first_byte ? 10'd0 : held_high_r;
    stopped_nxt     = stop;
    error_code_nxt  = err;
    kcons           = 3'd0;
    cp              = '0;
    n               = 3'd0;

    if (!stop) begin
      case (mode)
        M_SEL: begin
          kcons = 3'd1;
          if (b inside {[8'h01:8'h0B], 8'h10, 8'h13, 8'h14}) begin
            active_mode_nxt = M_UNSUP;
            error_code_nxt  = ST_UNSUP;
          end else if (b inside {8'h11, 8'h17}) begin
            active_mode_nxt = M_BE;
          end else if (b == 8'h16) begin
            active_mode_nxt = M_UCS;
          end else if (b == 8'h18) begin
            active_mode_nxt = M_LE;
          end else if (b inside {8'h00, 8'h12, 8'h15, [8'h0D:8'h0F], [8'h19:8'h1F]}) begin
            active_mode_nxt = M_PASS;
          end else begin
            // not a selector: it is the first data byte
            active_mode_nxt = M_PASS;
            cp = CP_W'(b);
            n  = 3'd1;
          end
        end
        M_PASS: begin
          kcons = 3'd1;
          cp    = CP_W'(b);
          n     = 3'd1;
        end
        M_UNSUP: begin
          kcons = 3'd1;
        end
        M_UCS, M_BE, M_LE: begin
          case (phase)
            2'd0, 2'd2: begin
              held_byte_nxt  = b;
              unit_phase_nxt = phase + 2'd1;
            end
            2'd1: begin
              unit_phase_nxt = 2'd0;
              if (mode == M_UCS || w < 16'hD800 || w > 16'hDFFF) begin
                kcons = 3'd2;
                cp    = CP_W'(w);
                n     = utf8_len(w);
              end else if (w > 16'hDBFF) begin
                stopped_nxt = 1'b1;
              end else begin
                held_high_nxt  = w[9:0];
                unit_phase_nxt = 2'd2;
              end
            end
            default: begin
              unit_phase_nxt = 2'd0;
              if (w >= 16'hDC00 && w <= 16'hDFFF) begin
                kcons = 3'd4;
                cp    = 21'h10000 + {1'b0, held_high_r, w[9:0]};
                n     = 3'd4;
              end else begin
                stopped_nxt    = 1'b1;
                error_code_nxt = ST_BAD_PAIR;
              end
            end
          endcase
        end
        default: ;
      endcase
    end

    out_count_nxt = ocnt + OCW'(n);
    if (n != 3'd0 && out_count_nxt >= OCW'(OUT_LIMIT - 4)) begin
      stopped_nxt    = 1'b1;
      error_code_nxt = ST_FULL;
    end

    icnt_sum     = {1'b0, icnt} + (CNT_W + 1)'(kcons);
    in_count_nxt = icnt_sum[CNT_W] ? CNT_MAX : icnt_sum[CNT_W-1:0];
  end

  assign q_push         = accept && (n != 3'd0 || in_data.last_byte);
  assign q_job.code     = cp;
  assign q_job.nbytes   = n;
  assign q_job.last     = in_data.last_byte;
  assign q_job.status   = error_code_nxt;
  assign q_job.consumed = in_count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fallback_r    <= 2'd0;
      active_mode_r <= M_SEL;
      unit_phase_r  <= 2'd0;
      held_byte_r   <= 8'd0;
      held_high_r   <= 10'd0;
      stopped_r     <= 1'b0;
      in_count_r    <= '0;
      out_count_r   <= '0;
      error_code_r  <= ST_OK;
    end else begin
      if (cfg_we) begin
        fallback_r <= cfg_wdata;
      end
      if (accept) begin
        active_mode_r <= active_mode_nxt;
        unit_phase_r  <= unit_phase_nxt;
        held_byte_r   <= held_byte_nxt;
        held_high_r   <= held_high_nxt;
        stopped_r     <= stopped_nxt;
        in_count_r    <= in_count_nxt;
        out_count_r   <= out_count_nxt;
        error_code_r  <= error_code_nxt;
      end
    end
  end

endmodule

[hw/rtl/dtu_queue.sv]
// ----------------------------------------------------------------------------
// dtu_queue
// Small job queue between the classifier and the UTF-8 serializer.
// ----------------------------------------------------------------------------
module dtu_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dtu_pkg::job_t      push_job,
  input  logic               pop,
  output dtu_pkg::job_t      head,
  output dtu_pkg::q_status_t stat
);
  import dtu_pkg::*;

  localparam int QAW = $clog2(Q_DEPTH);

  job_t           mem_r [Q_DEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == (QAW + 1)'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[hw/rtl/dtu_back.sv]
// ----------------------------------------------------------------------------
// dtu_back
// Expands queued code points into UTF-8 result transactions, one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module dtu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  dtu_pkg::q_status_t q_stat,
  input  dtu_pkg::job_t      q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output dtu_pkg::out_item_t out_data
);
  import dtu_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  out_item_t  data_r;
  logic [1:0] last_idx;
  logic       fin;
  logic       load;
  logic       take;
  logic       end_item;

  function automatic logic [7:0] enc_byte(input logic [CP_W-1:0] c, input logic [2:0] n,
                                          input logic [1:0] k);
    logic [7:0] r;
    case (n)
      3'd2:    r = (k == 2'd0) ? {3'b110, c[10:6]} : {2'b10, c[5:0]};
      3'd3: begin
        case (k)
          2'd0:    r = {4'b1110, c[15:12]};
          2'd1:    r = {2'b10, c[11:6]};
          default: r = {2'b10, c[5:0]};
        endcase
      end
      3'd4: begin
        case (k)
          2'd0:    r = {5'b11110, c[20:18]};
          2'd1:    r = {2'b10, c[17:12]};
          2'd2:    r = {2'b10, c[11:6]};
          default: r = {2'b10, c[5:0]};
        endcase
      end
      // single bytes, passthrough bytes included
      default: r = c[7:0];
    endcase
    return r;
  endfunction

  assign last_idx = (q_head.nbytes == 3'd0) ? 2'd0 : 2'(q_head.nbytes - 3'd1);
  assign fin      = (idx_r == last_idx);
  assign load     = !valid_r || !out_stall;
  assign take     = load && !q_stat.empty;
  assign q_pop    = take && fin;
  assign end_item = q_head.last && fin;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (take) begin
      idx_nxt   = fin ? 2'd0 : idx_r + 2'd1;
      valid_nxt = 1'b1;
    end else if (load) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r.out_byte       <= (q_head.nbytes == 3'd0) ? 8'd0 :
                               enc_byte(q_head.code, q_head.nbytes, idx_r);
      data_r.out_valid      <= (q_head.nbytes != 3'd0);
      data_r.out_last       <= end_item;
      data_r.status         <= end_item ? q_head.status : ST_OK;
      data_r.consumed_count <= end_item ? q_head.consumed : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[hw/rtl/dvb_text_to_utf8_transcoder.sv]
// ----------------------------------------------------------------------------
// dvb_text_to_utf8_transcoder
// Broadcast text string bytes in, UTF-8 bytes out, with string end status.
// ----------------------------------------------------------------------------
// One input byte is accepted per cycle while the four-entry job queue has
// room. Each byte gives zero to four result transactions (an end marker when
// a final byte emits nothing), and the output serializer sends one per cycle
// while out_stall is low; a code unit of two bytes that expands to three
// UTF-8 bytes sets the sustained rate. The job of a byte is written into the
// queue, and its first result is then registered in the output stage.
// The fallback setting from cfg_wdata is sampled when a byte with first_byte
// arrives. No clearing pass after reset.
module dvb_text_to_utf8_transcoder #(
  parameter int OUT_LIMIT = dtu_pkg::OUT_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  dtu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dtu_pkg::out_item_t out_data
);
  import dtu_pkg::*;

  q_status_t q_stat;
  job_t      q_job;
  job_t      q_head;
  logic      q_push;
  logic      q_pop;

  dtu_front #(
    .OUT_LIMIT(OUT_LIMIT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  dtu_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(q_job),
    .pop     (q_pop),
    .head    (q_head),
    .stat    (q_stat)
  );

  dtu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // queue can never be both full and empty
  a_q_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("job queue full and empty at once");

  // only the last transaction of a string carries status and count
  a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.out_last) |->
      (out_data.status == ST_OK && out_data.consumed_count == '0))
    else $error("status or count on a non-final transaction");

  // an end marker is always the last transaction of its string
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.out_valid) |-> out_data.out_last)
    else $error("end marker without last flag");

  // nothing leaves the queue that was not put in
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty job queue");

endmodule
